FILE: src/sbc_pkg.sv
// shared constants, pipeline word type and helper functions for the bcd calendar
package sbc_pkg;

  // second counts
  localparam logic [31:0] UTC_OFFSET = 32'd946684800;
  localparam logic [31:0] QUAD_SECS  = 32'd126230400;
  localparam logic [16:0] DAY_SECS   = 17'd86400;
  localparam logic [11:0] HOUR_SECS  = 12'd3600;
  localparam logic [5:0]  MIN_SECS   = 6'd60;

  // reciprocals for division by constants; the estimate is low by at most one
  localparam logic [13:0] QUAD_RECIP = 14'd8710;    // floor(2^40 / 126230400)
  localparam logic [19:0] DAY_RECIP  = 20'd795364;  // floor(2^36 / 86400)
  localparam logic [10:0] HOUR_RECIP = 11'd1165;    // floor(2^22 / 3600)
  localparam logic [12:0] MIN_RECIP  = 13'd4369;    // floor(2^18 / 60)
  localparam logic [7:0]  BCD_RECIP  = 8'd205;      // floor(n / 10) = (n * 205) >> 11

  // first day of years 1..3 within a four-year period
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  // word carried down the pipeline
  typedef struct packed {
    logic        valid;
    logic        unset;
    logic [31:0] secs;
    logic [5:0]  quads;
    logic [27:0] rem;
    logic [10:0] days;
    logic [17:0] tod;
    logic [7:0]  year;
    logic        leap;
    logic [8:0]  doy;
    logic [3:0]  mon;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [12:0] rs;
    logic [5:0]  minute;
    logic [6:0]  sec;
  } pipe_t;

  // first day of month idx (0 = january) within the year
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd365;
    endcase
    return base + {8'd0, leap & (idx >= 4'd2)};
  endfunction

  // two low decimal digits of an 8-bit value below 200
  function automatic logic [7:0] bcd8(input logic [7:0] n);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [3:0]  tens_digit;
    logic [7:0]  ones;
    prod = 16'(n) * 16'(BCD_RECIP);
    tens = prod[15:11];
    ones = n - 8'(tens) * 8'd10;
    tens_digit = (tens >= 5'd10) ? 4'(tens - 5'd10) : tens[3:0];
    return {tens_digit, ones[3:0]};
  endfunction

endpackage

FILE: src/sbc_in_if.sv
// input channel: mode and second count
interface sbc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] seconds;

  modport source (output valid, func, seconds, input ready);
  modport sink   (input valid, func, seconds, output ready);
endinterface

FILE: src/sbc_out_if.sv
// output channel: six bcd calendar fields
interface sbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_bcd;
  logic [4:0] month_bcd;
  logic [5:0] day_bcd;
  logic [5:0] hour_bcd;
  logic [6:0] minute_bcd;
  logic [6:0] second_bcd;

  modport source (output valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd,
                  second_bcd, input ready);
  modport sink   (input valid, year_bcd, month_bcd, day_bcd, hour_bcd, minute_bcd,
                  second_bcd, output ready);
endinterface

FILE: src/sbc_quad_div.sv
// epoch adjust and split of the count into four-year periods and remainder
module sbc_quad_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic                func,
  input  logic [31:0]         seconds,
  output sbc_pkg::pipe_t      q
);

  sbc_pkg::pipe_t st_a, st_a_next;
  sbc_pkg::pipe_t st_b, st_b_next;
  sbc_pkg::pipe_t st_c, st_c_next;
  sbc_pkg::pipe_t st_d, st_d_next;

  // stage a: utc offset and unset detect
  always_comb begin
    st_a_next = '0;
    st_a_next.valid = in_valid;
    st_a_next.unset = func && (seconds == 32'd0);
    st_a_next.secs  = func ? seconds - sbc_pkg::UTC_OFFSET : seconds;
  end

  // stage b: quotient estimate by reciprocal
  always_comb begin
    logic [45:0] qprod;
    qprod = 46'(st_a.secs) * 46'(sbc_pkg::QUAD_RECIP);
    st_b_next = st_a;
    st_b_next.quads = qprod[45:40];
  end

  // stage c: remainder of the estimate
  always_comb begin
    logic [31:0] back;
    back = 32'(st_b.quads) * sbc_pkg::QUAD_SECS;
    st_c_next = st_b;
    st_c_next.rem = 28'(st_b.secs - back);
  end

  // stage d: one correction step
  always_comb begin
    st_d_next = st_c;
    if (st_c.rem >= 28'(sbc_pkg::QUAD_SECS)) begin
      st_d_next.quads = st_c.quads + 6'd1;
      st_d_next.rem   = st_c.rem - 28'(sbc_pkg::QUAD_SECS);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st_a.valid <= 1'b0;
      st_b.valid <= 1'b0;
      st_c.valid <= 1'b0;
      st_d.valid <= 1'b0;
    end else if (en) begin
      st_a <= st_a_next;
      st_b <= st_b_next;
      st_c <= st_c_next;
      st_d <= st_d_next;
    end
  end

  assign q = st_d;

endmodule

FILE: src/sbc_day_split.sv
// day number and time of day, then year within period, month and day of month
module sbc_day_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sbc_pkg::pipe_t d,
  output sbc_pkg::pipe_t q
);

  sbc_pkg::pipe_t st_e, st_e_next;
  sbc_pkg::pipe_t st_f, st_f_next;
  sbc_pkg::pipe_t st_g, st_g_next;
  sbc_pkg::pipe_t st_h, st_h_next;
  sbc_pkg::pipe_t st_i, st_i_next;

  // stage e: day estimate by reciprocal
  always_comb begin
    logic [46:0] dprod;
    dprod = 47'(d.rem[26:0]) * 47'(sbc_pkg::DAY_RECIP);
    st_e_next = d;
    st_e_next.days = dprod[46:36];
  end

  // stage f: time of day for the estimate
  always_comb begin
    logic [27:0] back;
    logic [27:0] diff;
    back = 28'(st_e.days) * 28'(sbc_pkg::DAY_SECS);
    diff = st_e.rem - back;
    st_f_next = st_e;
    st_f_next.tod = diff[17:0];
  end

  // stage g: one correction step
  always_comb begin
    st_g_next = st_f;
    if (st_f.tod >= 18'(sbc_pkg::DAY_SECS)) begin
      st_g_next.days = st_f.days + 11'd1;
      st_g_next.tod  = st_f.tod - 18'(sbc_pkg::DAY_SECS);
    end
  end

  // stage h: year within the period, first year is leap
  always_comb begin
    logic [1:0]  y;
    logic [10:0] ys;
    logic [10:0] diff;
    if (st_g.days >= sbc_pkg::YEAR3_START) begin
      y  = 2'd3;
      ys = sbc_pkg::YEAR3_START;
    end else if (st_g.days >= sbc_pkg::YEAR2_START) begin
      y  = 2'd2;
      ys = sbc_pkg::YEAR2_START;
    end else if (st_g.days >= sbc_pkg::YEAR1_START) begin
      y  = 2'd1;
      ys = sbc_pkg::YEAR1_START;
    end else begin
      y  = 2'd0;
      ys = 11'd0;
    end
    diff = st_g.days - ys;
    st_h_next = st_g;
    st_h_next.year = {st_g.quads, y};
    st_h_next.leap = (y == 2'd0);
    st_h_next.doy  = diff[8:0];
  end

  // stage i: month by parallel compares, then day of month
  always_comb begin
    logic [3:0] cnt;
    logic [8:0] dm;
    cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      cnt = cnt + {3'd0, (st_h.doy >= sbc_pkg::month_start(st_h.leap, 4'(k)))};
    end
    dm = st_h.doy - sbc_pkg::month_start(st_h.leap, cnt) + 9'd1;
    st_i_next = st_h;
    st_i_next.mon  = cnt + 4'd1;
    st_i_next.mday = dm[4:0];
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st_e.valid <= 1'b0;
      st_f.valid <= 1'b0;
      st_g.valid <= 1'b0;
      st_h.valid <= 1'b0;
      st_i.valid <= 1'b0;
    end else if (en) begin
      st_e <= st_e_next;
      st_f <= st_f_next;
      st_g <= st_g_next;
      st_h <= st_h_next;
      st_i <= st_i_next;
    end
  end

  assign q = st_i;

endmodule

FILE: src/sbc_tod_split.sv
// time of day into hour, minute and second
module sbc_tod_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  sbc_pkg::pipe_t d,
  output sbc_pkg::pipe_t q
);

  sbc_pkg::pipe_t st_j, st_j_next;
  sbc_pkg::pipe_t st_k, st_k_next;
  sbc_pkg::pipe_t st_l, st_l_next;
  sbc_pkg::pipe_t st_m, st_m_next;
  sbc_pkg::pipe_t st_n, st_n_next;
  sbc_pkg::pipe_t st_o, st_o_next;

  // stage j: hour estimate
  always_comb begin
    logic [26:0] hprod;
    hprod = 27'(d.tod[16:0]) * 27'(sbc_pkg::HOUR_RECIP);
    st_j_next = d;
    st_j_next.hour = hprod[26:22];
  end

  // stage k: seconds within the hour, raw
  always_comb begin
    logic [17:0] back;
    logic [17:0] diff;
    back = 18'(st_j.hour) * 18'(sbc_pkg::HOUR_SECS);
    diff = st_j.tod - back;
    st_k_next = st_j;
    st_k_next.rs = diff[12:0];
  end

  // stage l: hour correction
  always_comb begin
    st_l_next = st_k;
    if (st_k.rs >= 13'(sbc_pkg::HOUR_SECS)) begin
      st_l_next.hour = st_k.hour + 5'd1;
      st_l_next.rs   = st_k.rs - 13'(sbc_pkg::HOUR_SECS);
    end
  end

  // stage m: minute estimate
  always_comb begin
    logic [23:0] mprod;
    mprod = 24'(st_l.rs[11:0]) * 24'(sbc_pkg::MIN_RECIP);
    st_m_next = st_l;
    st_m_next.minute = mprod[23:18];
  end

  // stage n: seconds within the minute, raw
  always_comb begin
    logic [12:0] back;
    logic [12:0] diff;
    back = 13'(st_m.minute) * 13'(sbc_pkg::MIN_SECS);
    diff = st_m.rs - back;
    st_n_next = st_m;
    st_n_next.sec = diff[6:0];
  end

  // stage o: minute correction
  always_comb begin
    st_o_next = st_n;
    if (st_n.sec >= 7'(sbc_pkg::MIN_SECS)) begin
      st_o_next.minute = st_n.minute + 6'd1;
      st_o_next.sec    = st_n.sec - 7'(sbc_pkg::MIN_SECS);
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st_j.valid <= 1'b0;
      st_k.valid <= 1'b0;
      st_l.valid <= 1'b0;
      st_m.valid <= 1'b0;
      st_n.valid <= 1'b0;
      st_o.valid <= 1'b0;
    end else if (en) begin
      st_j <= st_j_next;
      st_k <= st_k_next;
      st_l <= st_l_next;
      st_m <= st_m_next;
      st_n <= st_n_next;
      st_o <= st_o_next;
    end
  end

  assign q = st_o;

endmodule

FILE: src/seconds_to_bcd_calendar.sv
// top level: second count to bcd date and time, sixteen-stage pipeline
//
//   port  | dir | payload                                   | handshake
//   din   | in  | func, seconds                             | valid/ready
//   dout  | out | year/month/day/hour/minute/second in bcd  | valid/ready
//
// one word per cycle in and out while dout is taken; the stages form the chain of
// reciprocal multiply, back-multiply and correction steps for each divisor.
// rst is synchronous and clears only the stage valid bits.
// while dout holds a word that is not taken, every stage freezes and din.ready
// drops; nothing is lost or repeated.
module seconds_to_bcd_calendar (
  input logic       clk,
  input logic       rst,
  sbc_in_if.sink    din,
  sbc_out_if.source dout
);

  sbc_pkg::pipe_t quad_q;
  sbc_pkg::pipe_t day_q;
  sbc_pkg::pipe_t tod_q;

  logic       adv;
  logic       out_valid;
  logic [7:0] year_r;
  logic [4:0] month_r;
  logic [5:0] day_r;
  logic [5:0] hour_r;
  logic [6:0] minute_r;
  logic [6:0] second_r;
  logic [7:0] month_w;
  logic [7:0] day_w;
  logic [7:0] hour_w;
  logic [7:0] minute_w;
  logic [7:0] second_w;

  // whole pipe moves when the output register is free or being taken
  assign adv       = !out_valid || dout.ready;
  assign din.ready = adv;

  sbc_quad_div u_quad (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (din.valid),
    .func     (din.func),
    .seconds  (din.seconds),
    .q        (quad_q)
  );

  sbc_day_split u_day (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (quad_q),
    .q   (day_q)
  );

  sbc_tod_split u_tod (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .d   (day_q),
    .q   (tod_q)
  );

  // bcd conversion of the finished fields
  assign month_w  = sbc_pkg::bcd8({4'd0, tod_q.mon});
  assign day_w    = sbc_pkg::bcd8({3'd0, tod_q.mday});
  assign hour_w   = sbc_pkg::bcd8({3'd0, tod_q.hour});
  assign minute_w = sbc_pkg::bcd8({2'd0, tod_q.minute});
  assign second_w = sbc_pkg::bcd8({1'b0, tod_q.sec});

  // output register, all zero for unset utc
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tod_q.valid;
    end
    if (adv) begin
      if (tod_q.unset) begin
        year_r   <= 8'd0;
        month_r  <= 5'd0;
        day_r    <= 6'd0;
        hour_r   <= 6'd0;
        minute_r <= 7'd0;
        second_r <= 7'd0;
      end else begin
        year_r   <= sbc_pkg::bcd8(tod_q.year);
        month_r  <= month_w[4:0];
        day_r    <= day_w[5:0];
        hour_r   <= hour_w[5:0];
        minute_r <= minute_w[6:0];
        second_r <= second_w[6:0];
      end
    end
  end

  assign dout.valid      = out_valid;
  assign dout.year_bcd   = year_r;
  assign dout.month_bcd  = month_r;
  assign dout.day_bcd    = day_r;
  assign dout.hour_bcd   = hour_r;
  assign dout.minute_bcd = minute_r;
  assign dout.second_bcd = second_r;

`ifndef ASSERT_OFF
  // a zero month only comes with the all-zero unset word
  a_unset_all_zero: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.month_bcd == 5'd0) |->
      (dout.day_bcd == 6'd0 && dout.year_bcd == 8'd0 && dout.hour_bcd == 6'd0 &&
       dout.minute_bcd == 7'd0 && dout.second_bcd == 7'd0))
    else $error("month zero without unset word");

  // month and day are legal bcd in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.month_bcd[3:0] <= 4'd9 &&
                    (dout.month_bcd[4] == 1'b0 || dout.month_bcd[3:0] <= 4'd2) &&
                    dout.day_bcd[3:0] <= 4'd9 &&
                    (dout.day_bcd[5:4] <= 2'd2 || dout.day_bcd[3:0] <= 4'd1)))
    else $error("date field out of range");

  // hour below 24 after the hour correction
  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.hour_bcd[3:0] <= 4'd9 && dout.hour_bcd[5:4] <= 2'd2 &&
                    (dout.hour_bcd[5:4] != 2'd2 || dout.hour_bcd[3:0] <= 4'd3)))
    else $error("hour out of range");

  // minute and second below 60
  a_min_sec_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> (dout.minute_bcd[3:0] <= 4'd9 && dout.minute_bcd[6:4] <= 3'd5 &&
                    dout.second_bcd[3:0] <= 4'd9 && dout.second_bcd[6:4] <= 3'd5))
    else $error("minute or second out of range");
`endif

endmodule
